>>> hdl/stxf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxf_pkg
// types, codes and reset values shared by the framer core and its step logic
// ----------------------------------------------------------------------------
package stxf_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = 3;

    localparam logic [1:0] FUNC_TX   = 2'd0;
    localparam logic [1:0] FUNC_RX   = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [1:0] KIND_LINE    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD     = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CHECK   = 2'd2;

    localparam logic [1:0] REG_HAS_ECHO   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT    = 2'd1;
    localparam logic [1:0] REG_START_MARK = 2'd2;
    localparam logic [1:0] REG_END_MARK   = 2'd3;

    localparam logic [15:0] RST_TIMEOUT    = 16'd2000;
    localparam logic [7:0]  RST_START_MARK = 8'h02;
    localparam logic [7:0]  RST_END_MARK   = 8'h03;
    localparam logic [7:0]  CHECK_INIT     = 8'h00;
    localparam logic [15:0] TICKS_MAX      = 16'hffff;

    typedef struct packed {
        logic        has_echo;
        logic [15:0] reply_timeout_ms;
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  rx_phase;
        logic [7:0]  rx_check;
        logic [7:0]  tx_check;
        logic        tx_inside_msg;
        logic        awaiting_reply;
        logic        echo_pending;
        logic [15:0] wait_ticks;
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_out;
        logic [1:0] status;
        logic       run_last;
    } t_result;

endpackage

>>> hdl/stxf_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxf_step
// next state and result list for one transaction of the framer
// ----------------------------------------------------------------------------
module stxf_step (
    input  logic [1:0]      i_func,
    input  logic [7:0]      i_data,
    input  logic            i_msg_end,
    input  stxf_pkg::t_cfg   i_cfg,
    input  stxf_pkg::t_state i_state,
    output stxf_pkg::t_state o_state,
    output stxf_pkg::t_result o_res [stxf_pkg::MAX_RESULTS],
    output logic [stxf_pkg::CNT_W-1:0] o_count
);
    import stxf_pkg::*;

    t_state            st;
    t_result           res [MAX_RESULTS];
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  last_idx;
    logic [7:0]        chk;
    logic [15:0]       wt;

    always_comb begin
        st  = i_state;
        cnt = '0;
        chk = '0;
        wt  = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k] = '0;
        end

        case (i_func)
            FUNC_TX: begin
                if (!st.tx_inside_msg) begin
                    st.rx_phase       = PH_HUNT;
                    st.rx_check       = CHECK_INIT;
                    st.awaiting_reply = 1'b0;
                    st.echo_pending   = 1'b0;
                    st.wait_ticks     = '0;
                    st.tx_check       = CHECK_INIT;
                    st.tx_inside_msg  = 1'b1;
                    res[cnt[1:0]] = '{KIND_LINE, i_cfg.start_marker, STAT_OK, 1'b0};
                    cnt = cnt + 1'b1;
                end
                res[cnt[1:0]] = '{KIND_LINE, i_data, STAT_OK, 1'b0};
                cnt = cnt + 1'b1;
                st.tx_check = st.tx_check ^ i_data;
                if (i_msg_end) begin
                    chk = st.tx_check ^ i_cfg.end_marker;
                    res[cnt[1:0]] = '{KIND_LINE, i_cfg.end_marker, STAT_OK, 1'b0};
                    cnt = cnt + 1'b1;
                    res[cnt[1:0]] = '{KIND_LINE, chk, STAT_OK, 1'b0};
                    cnt = cnt + 1'b1;
                    st.tx_check       = CHECK_INIT;
                    st.tx_inside_msg  = 1'b0;
                    st.awaiting_reply = 1'b1;
                    st.wait_ticks     = '0;
                    st.echo_pending   = i_cfg.has_echo;
                end
            end
            FUNC_RX: begin
                if (st.rx_phase == PH_PAYLOAD) begin
                    st.rx_check = st.rx_check ^ i_data;
                    if (i_data == i_cfg.end_marker) begin
                        st.rx_phase = PH_CHECK;
                    end else if (!st.echo_pending) begin
                        res[cnt[1:0]] = '{KIND_PAYLOAD, i_data, STAT_OK, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                end else if (st.rx_phase == PH_CHECK) begin
                    if (!st.echo_pending) begin
                        res[cnt[1:0]] = '{KIND_END, 8'h00,
                            (i_data == st.rx_check) ? STAT_OK : STAT_BAD, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    st.rx_phase = PH_HUNT;
                    st.rx_check = CHECK_INIT;
                    if (st.echo_pending) begin
                        st.echo_pending = 1'b0;
                        st.wait_ticks   = '0;
                    end else begin
                        st.awaiting_reply = 1'b0;
                    end
                end else begin
                    st.rx_phase = PH_HUNT;
                    if (i_data == i_cfg.start_marker) begin
                        st.rx_phase = PH_PAYLOAD;
                        st.rx_check = CHECK_INIT;
                    end
                end
            end
            FUNC_TICK: begin
                if (st.awaiting_reply && st.rx_phase == PH_HUNT) begin
                    wt = (st.wait_ticks == TICKS_MAX) ? st.wait_ticks
                                                       : st.wait_ticks + 16'd1;
                    st.wait_ticks = wt;
                    if (wt >= i_cfg.reply_timeout_ms) begin
                        res[cnt[1:0]] = '{KIND_END, 8'h00, STAT_TIMEOUT, 1'b0};
                        cnt = cnt + 1'b1;
                        if (st.echo_pending) begin
                            st.echo_pending = 1'b0;
                            st.wait_ticks   = '0;
                        end else begin
                            st.awaiting_reply = 1'b0;
                        end
                    end
                end
            end
            default: begin
                st = i_state;
            end
        endcase

        last_idx = cnt - 1'b1;
        if (cnt != '0) begin
            res[last_idx[1:0]].run_last = 1'b1;
        end
    end

    assign o_state = st;
    assign o_count = cnt;

    always_comb begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            o_res[k] = res[k];
        end
    end

endmodule

>>> hdl/stx_etx_lrc_link_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_lrc_link_framer_core
// start/end marker framer with xor check for a serial command link
// ----------------------------------------------------------------------------
// A transaction is taken in the cycle it is offered whenever the result queue
// is empty or its last entry leaves in that cycle. The step logic turns the
// transaction combinationally into zero to four results for a four-entry
// result queue that presents one per cycle unless the output stalls; a
// transmit byte yields one to four (four for a one-byte message), a receive
// byte or tick at most one. Registers are to be written over the apb port
// only while no transaction is pending; the block does not enforce this.
module stx_etx_lrc_link_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data,
    input  logic        i_msg_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte_out,
    output logic [1:0]  o_status,
    output logic        o_run_last
);
    import stxf_pkg::*;

    t_cfg             r_cfg;
    t_state           r_state;
    t_state           n_state;
    t_result          r_res [MAX_RESULTS];
    t_result          n_res [MAX_RESULTS];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             in_accept;
    logic             out_accept;
    logic             can_load;
    logic             cfg_wr;

    stxf_step u_step (
        .i_func    (i_func),
        .i_data    (i_data),
        .i_msg_end (i_msg_end),
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_res     (n_res),
        .o_count   (n_cnt)
    );

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign out_accept = o_out_valid && !i_out_stall;
    assign can_load   = (r_cnt == '0) || (r_cnt == CNT_W'(1) && out_accept);
    assign o_in_stall = !can_load;
    assign in_accept  = i_in_valid && can_load;

    always_comb begin
        unique case (paddr[3:2])
            REG_HAS_ECHO:   prdata = {31'd0, r_cfg.has_echo};
            REG_TIMEOUT:    prdata = {16'd0, r_cfg.reply_timeout_ms};
            REG_START_MARK: prdata = {24'd0, r_cfg.start_marker};
            REG_END_MARK:   prdata = {24'd0, r_cfg.end_marker};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.has_echo         <= 1'b0;
            r_cfg.reply_timeout_ms <= RST_TIMEOUT;
            r_cfg.start_marker     <= RST_START_MARK;
            r_cfg.end_marker       <= RST_END_MARK;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_HAS_ECHO:   r_cfg.has_echo         <= pwdata[0];
                REG_TIMEOUT:    r_cfg.reply_timeout_ms <= pwdata[15:0];
                REG_START_MARK: r_cfg.start_marker     <= pwdata[7:0];
                REG_END_MARK:   r_cfg.end_marker       <= pwdata[7:0];
                default:        r_cfg.has_echo         <= r_cfg.has_echo;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.rx_phase       <= PH_HUNT;
            r_state.rx_check       <= CHECK_INIT;
            r_state.tx_check       <= CHECK_INIT;
            r_state.tx_inside_msg  <= 1'b0;
            r_state.awaiting_reply <= 1'b0;
            r_state.echo_pending   <= 1'b0;
            r_state.wait_ticks     <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // result queue, head at entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_accept) begin
            r_cnt <= n_cnt;
        end else if (out_accept) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                r_res[k] <= n_res[k];
            end
        end else if (out_accept) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_res[k] <= r_res[k+1];
            end
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_kind      = r_res[0].kind;
    assign o_byte_out  = r_res[0].byte_out;
    assign o_status    = r_res[0].status;
    assign o_run_last  = r_res[0].run_last;

endmodule
